// ----- rtl/u8v_pkg.sv -----
`default_nettype none

package u8v_pkg;

    localparam int unsigned ByteWidth = 8;
    localparam int unsigned CodeWidth = 21;
    localparam int unsigned CountWidth = 2;

    localparam logic [CodeWidth-1:0] MinCode2 = 21'h00080;
    localparam logic [CodeWidth-1:0] MinCode3 = 21'h00800;
    localparam logic [CodeWidth-1:0] MinCode4 = 21'h10000;
    localparam logic [CodeWidth-1:0] SurrogateLow = 21'h0d800;
    localparam logic [CodeWidth-1:0] SurrogateHigh = 21'h0dfff;
    localparam logic [CodeWidth-1:0] MaxCode = 21'h10ffff;

    localparam logic [ByteWidth-1:0] Lead2Mask = 8'he0;
    localparam logic [ByteWidth-1:0] Lead2Tag = 8'hc0;
    localparam logic [ByteWidth-1:0] Lead3Mask = 8'hf0;
    localparam logic [ByteWidth-1:0] Lead3Tag = 8'he0;
    localparam logic [ByteWidth-1:0] Lead4Mask = 8'hf8;
    localparam logic [ByteWidth-1:0] Lead4Tag = 8'hf0;
    localparam logic [ByteWidth-1:0] ContMask = 8'hc0;
    localparam logic [ByteWidth-1:0] ContTag = 8'h80;

    typedef struct packed {
        logic [ByteWidth-1:0] data_byte;
        logic                 last_byte;
    } byte_item_t;

    typedef struct packed {
        logic string_valid;
        logic string_done;
    } verdict_t;

    function automatic logic [CodeWidth-1:0] min_code(input logic [CountWidth-1:0] extra);
        logic [CodeWidth-1:0] result;
        begin
            unique case (extra)
                2'd1:    result = MinCode2;
                2'd2:    result = MinCode3;
                2'd3:    result = MinCode4;
                default: result = '0;
            endcase
            return result;
        end
    endfunction

endpackage

`default_nettype wire

// ----- rtl/u8v_ifs.sv -----
`default_nettype none

interface u8v_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface u8v_out_if;
    logic valid;
    logic ready;
    logic string_valid;
    logic string_done;

    modport source (output valid, output string_valid, output string_done, input ready);
    modport sink (input valid, input string_valid, input string_done, output ready);
endinterface

`default_nettype wire

// ----- rtl/u8v_in_stage.sv -----
`default_nettype none

module u8v_in_stage (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               up_valid,
    output logic                    up_ready,
    input  wire u8v_pkg::byte_item_t up_item,
    output logic                    dn_valid,
    input  wire logic               dn_ready,
    output u8v_pkg::byte_item_t     dn_item
);
    import u8v_pkg::*;

    logic       valid_reg;
    logic       valid_next;
    byte_item_t item_reg;

    assign up_ready = !valid_reg || dn_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (up_ready)
        begin
            valid_next = up_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            item_reg <= up_item;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_item = item_reg;

endmodule

`default_nettype wire

// ----- rtl/u8v_decode.sv -----
`default_nettype none

module u8v_decode (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                advance,
    input  wire u8v_pkg::byte_item_t item,
    output u8v_pkg::verdict_t        verdict
);
    import u8v_pkg::*;

    logic [CountWidth-1:0] pending_reg;
    logic [CountWidth-1:0] pending_next;
    logic [CountWidth-1:0] extra_reg;
    logic [CountWidth-1:0] extra_next;
    logic [CodeWidth-1:0]  accum_reg;
    logic [CodeWidth-1:0]  accum_next;
    logic                  error_reg;
    logic                  error_next;

    logic [CountWidth-1:0] dec_pending;
    logic [CountWidth-1:0] dec_extra;
    logic [CodeWidth-1:0]  dec_accum;
    logic                  dec_error;
    logic [ByteWidth-1:0]  b;

    assign b = item.data_byte;

    always_comb
    begin
        dec_pending = pending_reg;
        dec_extra = extra_reg;
        dec_accum = accum_reg;
        dec_error = error_reg;
        if (!error_reg)
        begin
            if (pending_reg == '0)
            begin
                priority if (b == '0)
                begin
                    dec_error = 1'b1;
                end
                else if (!b[ByteWidth-1])
                begin
                    dec_error = 1'b0;
                end
                else if ((b & Lead2Mask) == Lead2Tag)
                begin
                    dec_pending = 2'd1;
                    dec_extra = 2'd1;
                    dec_accum = {16'd0, b[4:0]};
                end
                else if ((b & Lead3Mask) == Lead3Tag)
                begin
                    dec_pending = 2'd2;
                    dec_extra = 2'd2;
                    dec_accum = {17'd0, b[3:0]};
                end
                else if ((b & Lead4Mask) == Lead4Tag)
                begin
                    dec_pending = 2'd3;
                    dec_extra = 2'd3;
                    dec_accum = {18'd0, b[2:0]};
                end
                else
                begin
                    dec_error = 1'b1;
                end
            end
            else if ((b & ContMask) != ContTag)
            begin
                dec_error = 1'b1;
            end
            else
            begin
                dec_accum = {accum_reg[CodeWidth-7:0], b[5:0]};
                dec_pending = pending_reg - 2'd1;
                if (dec_pending == '0)
                begin
                    if ((dec_accum < min_code(extra_reg))
                        || ((dec_accum >= SurrogateLow) && (dec_accum <= SurrogateHigh))
                        || (dec_accum > MaxCode))
                    begin
                        dec_error = 1'b1;
                    end
                end
            end
        end
    end

    always_comb
    begin
        pending_next = dec_pending;
        extra_next = dec_extra;
        accum_next = dec_accum;
        error_next = dec_error;
        verdict.string_done = item.last_byte;
        if (item.last_byte)
        begin
            verdict.string_valid = !dec_error && (dec_pending == '0);
            pending_next = '0;
            extra_next = '0;
            accum_next = '0;
            error_next = 1'b0;
        end
        else
        begin
            verdict.string_valid = !dec_error;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
            extra_reg <= '0;
            accum_reg <= '0;
            error_reg <= 1'b0;
        end
        else if (advance)
        begin
            pending_reg <= pending_next;
            extra_reg <= extra_next;
            accum_reg <= accum_next;
            error_reg <= error_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg <= extra_reg)
        else $error("Pending count exceeds the sequence length.");

    assert property (@(posedge clk) disable iff (!rst_n)
        advance && item.last_byte |=> (pending_reg == '0) && !error_reg)
        else $error("State not cleared after the last byte of a string.");

    assert property (@(posedge clk) disable iff (!rst_n)
        advance && error_reg && !item.last_byte |=> error_reg && $stable(pending_reg))
        else $error("Error state changed before the end of the string.");

endmodule

`default_nettype wire

// ----- rtl/utf8_stream_validator_unit.sv -----
`default_nettype none
// Bytes pass the input register, the decode logic and the result register in turn.
// One byte per cycle unless the output stalls; decode state updates per byte.
// The input register and the result register each stall only when full and blocked.
// Reset is asynchronous and active low; it empties both registers and clears
// the decode state so that the next byte starts a new string.

module utf8_stream_validator_unit (
    input  wire logic clk,
    input  wire logic rst_n,
    u8v_in_if.sink    stream,
    u8v_out_if.source verdict
);
    import u8v_pkg::*;

    byte_item_t in_item;
    byte_item_t dec_item;
    logic       dec_valid;
    logic       dec_ready;
    logic       advance;
    verdict_t   dec_verdict;
    verdict_t   result_reg;
    logic       out_valid_reg;
    logic       out_valid_next;

    assign in_item.data_byte = stream.data_byte;
    assign in_item.last_byte = stream.last_byte;

    u8v_in_stage u_in_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (stream.valid),
        .up_ready (stream.ready),
        .up_item  (in_item),
        .dn_valid (dec_valid),
        .dn_ready (dec_ready),
        .dn_item  (dec_item)
    );

    assign dec_ready = !out_valid_reg || verdict.ready;
    assign advance = dec_valid && dec_ready;

    u8v_decode u_decode (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .item    (dec_item),
        .verdict (dec_verdict)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (dec_ready)
        begin
            out_valid_next = dec_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg <= dec_verdict;
        end
    end

    assign verdict.valid = out_valid_reg;
    assign verdict.string_valid = result_reg.string_valid;
    assign verdict.string_done = result_reg.string_done;

endmodule

`default_nettype wire

// ----- tb/tb_utf8_stream_validator_unit.sv -----
`timescale 1ns / 100ps

module tb_utf8_stream_validator_unit;

    import u8v_pkg::*;

    localparam int StallLimit = 2000;
    localparam int TailCycles = 8;
    localparam int RandomBytes = 1900;

    typedef enum int unsigned {
        FLAW_NUL,
        FLAW_STRAY_CONT,
        FLAW_BAD_LEAD,
        FLAW_OVERLONG,
        FLAW_SURROGATE,
        FLAW_TOO_HIGH,
        FLAW_TRUNCATED,
        FLAW_BAD_CONT,
        FLAW_COUNT
    } flaw_t;

    logic clk;
    logic rst_n;

    u8v_in_if  stream_if ();
    u8v_out_if verdict_if ();

    utf8_stream_validator_unit uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .stream  (stream_if),
        .verdict (verdict_if)
    );

    logic [1:0]           dec_pending;
    logic [1:0]           dec_extra;
    logic [CodeWidth-1:0] dec_code;
    logic                 dec_err;

    verdict_t    verdict_q[$];
    logic [7:0]  str_buf[$];
    int unsigned sent_bytes;
    int unsigned fail_count;
    int unsigned idle_run;
    bit          gaps_on;

    initial
    begin
        clk = 1'b0;
    end

    always #10 clk = ~clk;

    function automatic int unsigned pick_delay(input int unsigned short_pct);
        int unsigned r;
        begin
            r = $urandom_range(0, 99);
            if (r < short_pct)
            begin
                return $urandom_range(1, 3);
            end
            if (r < 92)
            begin
                return 0;
            end
            return $urandom_range(10, 40);
        end
    endfunction

    task automatic add_byte(input logic [7:0] b);
        begin
            str_buf.insert(str_buf.size(), b);
        end
    endtask

    task automatic predict_verdict(input logic [7:0] b, input logic last, output verdict_t v);
        logic [CodeWidth-1:0] floor_code;
        begin
            if (!dec_err)
            begin
                if (dec_pending == 2'd0)
                begin
                    if (b == 8'h00)
                    begin
                        dec_err = 1'b1;
                    end
                    else if (b[7] == 1'b0)
                    begin
                        dec_err = 1'b0;
                    end
                    else if (b[7:5] == 3'b110)
                    begin
                        dec_pending = 2'd1;
                        dec_extra = 2'd1;
                        dec_code = {16'd0, b[4:0]};
                    end
                    else if (b[7:4] == 4'b1110)
                    begin
                        dec_pending = 2'd2;
                        dec_extra = 2'd2;
                        dec_code = {17'd0, b[3:0]};
                    end
                    else if (b[7:3] == 5'b11110)
                    begin
                        dec_pending = 2'd3;
                        dec_extra = 2'd3;
                        dec_code = {18'd0, b[2:0]};
                    end
                    else
                    begin
                        dec_err = 1'b1;
                    end
                end
                else if (b[7:6] != 2'b10)
                begin
                    dec_err = 1'b1;
                end
                else
                begin
                    dec_code = {dec_code[14:0], b[5:0]};
                    dec_pending = dec_pending - 2'd1;
                    if (dec_pending == 2'd0)
                    begin
                        case (dec_extra)
                            2'd1:    floor_code = MinCode2;
                            2'd2:    floor_code = MinCode3;
                            2'd3:    floor_code = MinCode4;
                            default: floor_code = '0;
                        endcase
                        if (dec_code < floor_code
                            || (dec_code >= SurrogateLow && dec_code <= SurrogateHigh)
                            || dec_code > MaxCode)
                        begin
                            dec_err = 1'b1;
                        end
                    end
                end
            end
            v.string_done = last;
            if (last)
            begin
                v.string_valid = !dec_err && dec_pending == 2'd0;
                dec_pending = '0;
                dec_extra = '0;
                dec_code = '0;
                dec_err = 1'b0;
            end
            else
            begin
                v.string_valid = !dec_err;
            end
        end
    endtask

    task automatic send_byte(input logic [7:0] b, input logic last);
        int unsigned gap;
        verdict_t    v;
        begin
            gap = gaps_on ? pick_delay(30) : 0;
            if (gap != 0)
            begin
                stream_if.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            stream_if.valid <= 1'b1;
            stream_if.data_byte <= b;
            stream_if.last_byte <= last;
            do @(posedge clk); while (!stream_if.ready);
            predict_verdict(b, last, v);
            verdict_q.insert(verdict_q.size(), v);
            sent_bytes++;
        end
    endtask

    task automatic send_string;
        int unsigned i;
        begin
            if (str_buf.size() == 0)
            begin
                add_byte(8'h41);
            end
            for (i = 0; i < str_buf.size(); i++)
            begin
                send_byte(str_buf[i], i == str_buf.size() - 1);
            end
        end
    endtask

    task automatic wait_drained;
        begin
            stream_if.valid <= 1'b0;
            while (verdict_q.size() != 0) @(posedge clk);
        end
    endtask

    function automatic logic [20:0] pick_code(input logic [20:0] lo, input logic [20:0] hi);
        begin
            if ($urandom_range(0, 9) < 3)
            begin
                case ($urandom_range(0, 3))
                    0:       return lo;
                    1:       return lo + 21'd1;
                    2:       return hi - 21'd1;
                    default: return hi;
                endcase
            end
            return 21'($urandom_range(hi, lo));
        end
    endfunction

    task automatic append_code(input logic [20:0] cp, input int unsigned n);
        begin
            case (n)
                1:
                begin
                    add_byte({1'b0, cp[6:0]});
                end
                2:
                begin
                    add_byte({3'b110, cp[10:6]});
                    add_byte({2'b10, cp[5:0]});
                end
                3:
                begin
                    add_byte({4'b1110, cp[15:12]});
                    add_byte({2'b10, cp[11:6]});
                    add_byte({2'b10, cp[5:0]});
                end
                default:
                begin
                    add_byte({5'b11110, cp[20:18]});
                    add_byte({2'b10, cp[17:12]});
                    add_byte({2'b10, cp[11:6]});
                    add_byte({2'b10, cp[5:0]});
                end
            endcase
        end
    endtask

    task automatic append_valid_char(input int unsigned n);
        begin
            case (n)
                1: append_code(pick_code(21'h1, 21'h7f), 1);
                2: append_code(pick_code(21'h80, 21'h7ff), 2);
                3:
                begin
                    if ($urandom_range(0, 1) == 0)
                    begin
                        append_code(pick_code(21'h800, 21'hd7ff), 3);
                    end
                    else
                    begin
                        append_code(pick_code(21'he000, 21'hffff), 3);
                    end
                end
                default: append_code(pick_code(21'h10000, 21'h10ffff), 4);
            endcase
        end
    endtask

    task automatic append_flaw;
        flaw_t       kind;
        int unsigned n;
        int unsigned start;
        int unsigned cut;
        int unsigned idx;
        logic [7:0]  b;
        begin
            kind = flaw_t'($urandom_range(0, FLAW_COUNT - 1));
            n = $urandom_range(2, 4);
            start = str_buf.size();
            case (kind)
                FLAW_NUL:        add_byte(8'h00);
                FLAW_STRAY_CONT: add_byte(8'($urandom_range(8'hbf, 8'h80)));
                FLAW_BAD_LEAD:   add_byte(8'($urandom_range(8'hff, 8'hf8)));
                FLAW_OVERLONG:
                begin
                    case (n)
                        2:       append_code(pick_code(21'h0, 21'h7f), 2);
                        3:       append_code(pick_code(21'h0, 21'h7ff), 3);
                        default: append_code(pick_code(21'h0, 21'hffff), 4);
                    endcase
                end
                FLAW_SURROGATE: append_code(pick_code(21'hd800, 21'hdfff), 3);
                FLAW_TOO_HIGH:  append_code(pick_code(21'h110000, 21'h1fffff), 4);
                FLAW_TRUNCATED:
                begin
                    append_valid_char(n);
                    cut = $urandom_range(1, n - 1);
                    repeat (cut) void'(str_buf.pop_back());
                end
                default:
                begin
                    append_valid_char(n);
                    idx = start + $urandom_range(1, n - 1);
                    do b = 8'($urandom_range(0, 255)); while (b[7:6] == 2'b10);
                    str_buf[idx] = b;
                end
            endcase
        end
    endtask

    task automatic build_random_string;
        int unsigned chars;
        int unsigned i;
        bit          clean;
        begin
            str_buf.delete();
            chars = ($urandom_range(0, 3) == 0) ? $urandom_range(6, 14) : $urandom_range(1, 5);
            if ($urandom_range(0, 19) == 0)
            begin
                repeat (chars) add_byte(8'($urandom_range(0, 255)));
            end
            else
            begin
                clean = 1'($urandom_range(0, 1));
                for (i = 0; i < chars; i++)
                begin
                    if (!clean && $urandom_range(0, 4) == 0)
                    begin
                        append_flaw();
                    end
                    else
                    begin
                        append_valid_char($urandom_range(1, 4));
                    end
                end
            end
        end
    endtask

    task automatic test_single_byte_chars;
        begin
            str_buf = {8'h41};
            send_string();
            str_buf = {8'h7f, 8'h01, 8'h00, 8'h41};
            send_string();
            str_buf = {8'hff};
            send_string();
        end
    endtask

    task automatic test_multibyte_chars;
        begin
            str_buf = {8'hc2, 8'h80, 8'hdf, 8'hbf};
            send_string();
            str_buf = {8'he0, 8'ha0, 8'h80};
            send_string();
            str_buf = {8'hf4, 8'h8f, 8'hbf, 8'hbf};
            send_string();
        end
    endtask

    task automatic test_malformed_sequences;
        begin
            str_buf = {8'hc0, 8'h80};
            send_string();
            str_buf = {8'hed, 8'ha0, 8'h80};
            send_string();
            str_buf = {8'hf4, 8'h90, 8'h80, 8'h80};
            send_string();
            str_buf = {8'hc2, 8'h41};
            send_string();
            str_buf = {8'he0, 8'ha0};
            send_string();
        end
    endtask

    task automatic test_random_strings;
        begin
            while (sent_bytes < RandomBytes)
            begin
                gaps_on = $urandom_range(0, 4) != 0;
                build_random_string();
                send_string();
            end
            gaps_on = 1'b1;
        end
    endtask

    task automatic test_drain_pause;
        begin
            repeat (4)
            begin
                build_random_string();
                send_string();
                wait_drained();
            end
        end
    endtask

    initial
    begin
        int unsigned run_len;
        int unsigned stall_len;
        forever
        begin
            run_len = ($urandom_range(0, 9) < 3) ? $urandom_range(20, 80) : $urandom_range(1, 6);
            stall_len = pick_delay(55);
            verdict_if.ready <= 1'b1;
            repeat (run_len) @(posedge clk);
            if (stall_len != 0)
            begin
                verdict_if.ready <= 1'b0;
                repeat (stall_len) @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        verdict_t want;
        if (rst_n && verdict_if.valid && verdict_if.ready)
        begin
            if (verdict_q.size() == 0)
            begin
                fail_count++;
                $display("%0t: unexpected transfer, actual valid=%0b done=%0b", $time,
                         verdict_if.string_valid, verdict_if.string_done);
            end
            else
            begin
                want = verdict_q[0];
                verdict_q.delete(0);
                if (want.string_valid !== verdict_if.string_valid
                    || want.string_done !== verdict_if.string_done)
                begin
                    fail_count++;
                    $display("%0t: expected valid=%0b done=%0b, actual valid=%0b done=%0b",
                             $time, want.string_valid, want.string_done,
                             verdict_if.string_valid, verdict_if.string_done);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((stream_if.valid && stream_if.ready) || (verdict_if.valid && verdict_if.ready))
        begin
            idle_run <= 0;
        end
        else
        begin
            idle_run <= idle_run + 1;
        end
        if (idle_run >= StallLimit)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin
        sent_bytes = 0;
        fail_count = 0;
        idle_run = 0;
        gaps_on = 1'b1;
        dec_pending = '0;
        dec_extra = '0;
        dec_code = '0;
        dec_err = 1'b0;
        rst_n <= 1'b0;
        stream_if.valid <= 1'b0;
        stream_if.data_byte <= '0;
        stream_if.last_byte <= 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        test_single_byte_chars();
        test_multibyte_chars();
        test_malformed_sequences();
        test_random_strings();
        test_drain_pause();

        wait_drained();
        repeat (TailCycles) @(posedge clk);
        if (fail_count == 0 && verdict_q.size() == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
